// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Fixed-latency implication.
`define ASSERT_DELAY(lbl, ante, dly, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##dly (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/ihm_pkg.sv
package ihm_pkg;

   localparam int COORD_BITS = 12;
   localparam int DIM_W      = 12;
   localparam int OH_W       = 12;
   localparam int QUO_BITS   = COORD_BITS + 1;
   localparam int CX_W       = COORD_BITS + 2;
   localparam int CY_W       = ((COORD_BITS > OH_W) ? COORD_BITS : OH_W) + 3;
   localparam int COEF_W     = 32;
   localparam int PROD_W     = COEF_W + CY_W;
   localparam int SUM_W      = 64;
   localparam int MAG_W      = 64;
   localparam int OFS_SHIFT  = 13;
   localparam int NUM_SHIFT  = 9;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 64;
   localparam int LATENCY    = QUO_BITS + 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_GAINS  = 4'd0,
      CSR_Y_GAINS  = 4'd1,
      CSR_W_GAINS  = 4'd2,
      CSR_X_OFFSET = 4'd3,
      CSR_Y_OFFSET = 4'd4,
      CSR_W_OFFSET = 4'd5,
      CSR_SRC_SIZE = 4'd6,
      CSR_OUT_HGT  = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic wzero;
      logic col_neg;
      logic row_neg;
      logic col_ovf;
      logic row_ovf;
   } div_ctrl_type;

   typedef struct packed {
      logic [MAG_W-1:0]    rem_col;
      logic [MAG_W-1:0]    rem_row;
      logic [MAG_W-1:0]    divisor;
      logic [QUO_BITS-1:0] quo_col;
      logic [QUO_BITS-1:0] quo_row;
   } div_lane_type;

endpackage

// File: rtl/inverse_homography_mapper_top.sv
// Channel  Ports                                          Handshake
// input    req_dest_row, req_dest_col                     start & !busy
// result   rsp_source_row, rsp_source_col, rsp_inside_res rsp_valid, one cycle
// config   csr_index, csr_wdata                           csr_we
//
// One transaction per cycle; each passes the product, sum, numerator, magnitude, divide and output stages.
// Latency is dominated by the quotient bit chain: one restoring divide step per stage.
// busy stays low; the receiver cannot stall, so the pipeline always advances.
// Synchronous reset clears valid bits and loads the identity map.
module inverse_homography_mapper_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [ihm_pkg::COORD_BITS-1:0]       req_dest_row,
   input  logic [ihm_pkg::COORD_BITS-1:0]       req_dest_col,
   output logic                                 rsp_valid,
   output logic [ihm_pkg::COORD_BITS-1:0]       rsp_source_row,
   output logic [ihm_pkg::COORD_BITS-1:0]       rsp_source_col,
   output logic                                 rsp_inside_res,
   input  logic                                 csr_we,
   input  logic [ihm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ihm_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import ihm_pkg::*;

   `include "assert_macros.svh"

   logic [63:0] xg_ff, yg_ff, wg_ff;
   logic signed [31:0] xo_ff, yo_ff, wo_ff;
   logic [23:0] size_ff;
   logic [OH_W-1:0] oh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         xg_ff   <= 64'd268435456;
         yg_ff   <= 64'd1152921504606846976;
         wg_ff   <= 64'd0;
         xo_ff   <= 32'sd0;
         yo_ff   <= 32'sd0;
         wo_ff   <= 32'sd16777216;
         size_ff <= 24'd2097664;
         oh_ff   <= 12'd512;
      end else if (csr_we) begin
         case (csr_index)
            CSR_X_GAINS:  xg_ff   <= csr_wdata;
            CSR_Y_GAINS:  yg_ff   <= csr_wdata;
            CSR_W_GAINS:  wg_ff   <= csr_wdata;
            CSR_X_OFFSET: xo_ff   <= signed'(csr_wdata[31:0]);
            CSR_Y_OFFSET: yo_ff   <= signed'(csr_wdata[31:0]);
            CSR_W_OFFSET: wo_ff   <= signed'(csr_wdata[31:0]);
            CSR_SRC_SIZE: size_ff <= csr_wdata[23:0];
            CSR_OUT_HGT:  oh_ff   <= csr_wdata[OH_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // stage 1: products
   logic signed [CX_W-1:0] cx_in;
   logic signed [CY_W-1:0] cy_in;
   logic signed [PROD_W-1:0] px0_ff, px1_ff, py0_ff, py1_ff, pw0_ff, pw1_ff;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   always_comb begin
      cx_in = signed'({1'b0, req_dest_col, 1'b1});
      cy_in = signed'(CY_W'({oh_ff, 1'b0})) - signed'(CY_W'(1))
            - signed'(CY_W'({req_dest_row, 1'b0}));
   end

   always_ff @(posedge clock) begin
      px0_ff <= PROD_W'(signed'(xg_ff[31:0]))  * PROD_W'(cx_in);
      px1_ff <= PROD_W'(signed'(xg_ff[63:32])) * PROD_W'(cy_in);
      py0_ff <= PROD_W'(signed'(yg_ff[31:0]))  * PROD_W'(cx_in);
      py1_ff <= PROD_W'(signed'(yg_ff[63:32])) * PROD_W'(cy_in);
      pw0_ff <= PROD_W'(signed'(wg_ff[31:0]))  * PROD_W'(cx_in);
      pw1_ff <= PROD_W'(signed'(wg_ff[63:32])) * PROD_W'(cy_in);
   end

   // stage 2: sums
   logic signed [SUM_W-1:0] xs_ff, ys_ff, ws_ff;
   always_ff @(posedge clock) begin
      xs_ff <= SUM_W'(px0_ff) + SUM_W'(px1_ff) + (SUM_W'(xo_ff) <<< OFS_SHIFT);
      ys_ff <= SUM_W'(py0_ff) + SUM_W'(py1_ff) + (SUM_W'(yo_ff) <<< OFS_SHIFT);
      ws_ff <= SUM_W'(pw0_ff) + SUM_W'(pw1_ff) + (SUM_W'(wo_ff) <<< OFS_SHIFT);
   end

   // stage 3: numerators and denominator
   logic signed [SUM_W-1:0] ncol_ff, nrow_ff, den_ff;
   logic wz3_ff;
   always_ff @(posedge clock) begin
      ncol_ff <= (xs_ff <<< NUM_SHIFT) - ws_ff;
      nrow_ff <= -ws_ff - (ys_ff <<< NUM_SHIFT);
      den_ff  <= ws_ff <<< 1;
      wz3_ff  <= (ws_ff == '0);
   end

   // stage 4: magnitudes
   logic [MAG_W-1:0] acol_ff, arow_ff, aden_ff;
   logic wz4_ff, cneg4_ff, rneg4_ff;
   always_ff @(posedge clock) begin
      acol_ff  <= ncol_ff[SUM_W-1] ? MAG_W'(-ncol_ff) : MAG_W'(ncol_ff);
      arow_ff  <= nrow_ff[SUM_W-1] ? MAG_W'(-nrow_ff) : MAG_W'(nrow_ff);
      aden_ff  <= den_ff[SUM_W-1]  ? MAG_W'(-den_ff)  : MAG_W'(den_ff);
      wz4_ff   <= wz3_ff;
      cneg4_ff <= ncol_ff[SUM_W-1] ^ den_ff[SUM_W-1];
      rneg4_ff <= nrow_ff[SUM_W-1] ^ den_ff[SUM_W-1];
   end

   // stage 5 and divide stages: restoring division, one quotient bit per stage
   div_ctrl_type ctrl_ff [0:QUO_BITS];
   div_lane_type lane_ff [0:QUO_BITS];
   logic [MAG_W+QUO_BITS-1:0] lim_in;
   div_lane_type step_in [0:QUO_BITS-1];

   assign lim_in = {aden_ff, {QUO_BITS{1'b0}}};

   always_comb begin
      for (int j = 0; j < QUO_BITS; j++) begin
         logic [MAG_W+QUO_BITS-1:0] sh;
         sh = {{QUO_BITS{1'b0}}, lane_ff[j].divisor} << (QUO_BITS - 1 - j);
         step_in[j] = lane_ff[j];
         if ({{QUO_BITS{1'b0}}, lane_ff[j].rem_col} >= sh) begin
            step_in[j].rem_col = lane_ff[j].rem_col - sh[MAG_W-1:0];
            step_in[j].quo_col[QUO_BITS-1-j] = 1'b1;
         end
         if ({{QUO_BITS{1'b0}}, lane_ff[j].rem_row} >= sh) begin
            step_in[j].rem_row = lane_ff[j].rem_row - sh[MAG_W-1:0];
            step_in[j].quo_row[QUO_BITS-1-j] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff[0].wzero   <= wz4_ff;
      ctrl_ff[0].col_neg <= cneg4_ff;
      ctrl_ff[0].row_neg <= rneg4_ff;
      ctrl_ff[0].col_ovf <= ({{QUO_BITS{1'b0}}, acol_ff} >= lim_in);
      ctrl_ff[0].row_ovf <= ({{QUO_BITS{1'b0}}, arow_ff} >= lim_in);
      lane_ff[0].rem_col <= acol_ff;
      lane_ff[0].rem_row <= arow_ff;
      lane_ff[0].divisor <= aden_ff;
      lane_ff[0].quo_col <= '0;
      lane_ff[0].quo_row <= '0;
      for (int k = 0; k < QUO_BITS; k++) begin
         lane_ff[k+1] <= step_in[k];
         ctrl_ff[k+1].wzero   <= ctrl_ff[k].wzero;
         ctrl_ff[k+1].col_neg <= ctrl_ff[k].col_neg;
         ctrl_ff[k+1].row_neg <= ctrl_ff[k].row_neg;
         ctrl_ff[k+1].col_ovf <= ctrl_ff[k].col_ovf;
         ctrl_ff[k+1].row_ovf <= ctrl_ff[k].row_ovf;
      end
      if (reset) begin
         for (int k = 0; k <= QUO_BITS; k++) ctrl_ff[k].valid <= 1'b0;
      end else begin
         ctrl_ff[0].valid <= v4_ff;
         for (int k = 0; k < QUO_BITS; k++) ctrl_ff[k+1].valid <= ctrl_ff[k].valid;
      end
   end

   // output stage
   localparam int RV_W = QUO_BITS + 2;
   div_ctrl_type fc;
   div_lane_type fl;
   logic frac_in, col_ok_in, row_ok_in, inside_in;
   logic signed [RV_W-1:0] rowv_in;
   logic [DIM_W-1:0] src_w, src_h;
   logic rsp_valid_ff, rsp_inside_ff;
   logic [COORD_BITS-1:0] rsp_row_ff, rsp_col_ff;

   always_comb begin
      fc    = ctrl_ff[QUO_BITS];
      fl    = lane_ff[QUO_BITS];
      src_w = size_ff[DIM_W-1:0];
      src_h = size_ff[2*DIM_W-1:DIM_W];
      frac_in = (fl.rem_row != '0);
      col_ok_in = !fc.col_ovf && (!fc.col_neg || fl.quo_col == '0)
                && (RV_W'(fl.quo_col) < RV_W'(src_w));
      rowv_in = signed'(RV_W'(src_h)) - signed'(RV_W'(fl.quo_row))
              - signed'(RV_W'(frac_in));
      if (rowv_in < 0 && frac_in) rowv_in = rowv_in + signed'(RV_W'(1));
      row_ok_in = fc.row_neg && !fc.row_ovf && (rowv_in >= 0)
                && (rowv_in < signed'(RV_W'(src_h)));
      inside_in = !fc.wzero && col_ok_in && row_ok_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         rsp_inside_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= fc.valid;
         rsp_inside_ff <= fc.valid & inside_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_row_ff <= inside_in ? COORD_BITS'(rowv_in) : '0;
      rsp_col_ff <= inside_in ? COORD_BITS'(fl.quo_col) : '0;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_source_row = rsp_row_ff;
   assign rsp_source_col = rsp_col_ff;

   `ASSERT_DELAY(a_latency, start && !busy, LATENCY, rsp_valid)
   `ASSERT_IMPL(a_inside_valid, rsp_inside_res, rsp_valid)
   `ASSERT_IMPL(a_zero_outside, rsp_valid && !rsp_inside_res,
                rsp_source_row == '0 && rsp_source_col == '0)

endmodule

// File: sim/tb_inverse_homography_mapper_top.sv
`timescale 1ns / 1ps

module tb_inverse_homography_mapper_top;
   import ihm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 4'd13;

   typedef struct {
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] col;
   } pixel_type;

   typedef struct {
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] col;
      logic                  hit;
   } fetch_addr_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [COORD_BITS-1:0] req_dest_row = '0;
   logic [COORD_BITS-1:0] req_dest_col = '0;
   logic                  rsp_valid;
   logic [COORD_BITS-1:0] rsp_source_row;
   logic [COORD_BITS-1:0] rsp_source_col;
   logic                  rsp_inside_res;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [63:0] m_xg, m_yg, m_wg;
   logic [31:0] m_xo, m_yo, m_wo;
   logic [23:0] m_size;
   logic [11:0] m_oh;

   pixel_type      pixel_queue[$];
   fetch_addr_type fetch_queue[$];
   int  idle_left = 0;
   bit  calm = 1'b0;
   bit  failed = 1'b0;

   inverse_homography_mapper_top dut (.*);

   always #10 clock = ~clock;

   function automatic longint sx32(logic [31:0] v);
      return longint'(signed'(v));
   endfunction

   function automatic fetch_addr_type map_pixel(pixel_type p);
      fetch_addr_type res;
      longint cx2, cy2, xs, ys, wt, den, colv, t, rm, rowv, hs, wsz;
      bit frac;
      res.row = '0;
      res.col = '0;
      res.hit = 1'b0;
      wsz = longint'(m_size[11:0]);
      hs  = longint'(m_size[23:12]);
      cx2 = 2 * longint'(p.col) + 1;
      cy2 = 2 * longint'(m_oh) - 1 - 2 * longint'(p.row);
      xs = sx32(m_xg[31:0]) * cx2 + sx32(m_xg[63:32]) * cy2 + sx32(m_xo) * 8192;
      ys = sx32(m_yg[31:0]) * cx2 + sx32(m_yg[63:32]) * cy2 + sx32(m_yo) * 8192;
      wt = sx32(m_wg[31:0]) * cx2 + sx32(m_wg[63:32]) * cy2 + sx32(m_wo) * 8192;
      if (wt != 0) begin
         den  = 2 * wt;
         colv = (xs * 512 - wt) / den;
         t    = (-wt - ys * 512) / den;
         rm   = (-wt - ys * 512) % den;
         frac = (rm != 0);
         if (frac && ((rm < 0) != (den < 0)))
            t = t - 1;
         rowv = hs + t;
         if (rowv < 0 && frac)
            rowv = rowv + 1;
         if (rowv >= 0 && rowv < hs && colv >= 0 && colv < wsz) begin
            res.hit = 1'b1;
            res.row = rowv[COORD_BITS-1:0];
            res.col = colv[COORD_BITS-1:0];
         end
      end
      return res;
   endfunction

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [63:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_X_GAINS:  m_xg = data;
         CSR_Y_GAINS:  m_yg = data;
         CSR_W_GAINS:  m_wg = data;
         CSR_X_OFFSET: m_xo = data[31:0];
         CSR_Y_OFFSET: m_yo = data[31:0];
         CSR_W_OFFSET: m_wo = data[31:0];
         CSR_SRC_SIZE: m_size = data[23:0];
         CSR_OUT_HGT:  m_oh = data[11:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_pixel(int row, int col);
      pixel_type p;
      p.row = row[COORD_BITS-1:0];
      p.col = col[COORD_BITS-1:0];
      pixel_queue.push_back(p);
   endtask

   task automatic drain();
      wait (pixel_queue.size() == 0 && fetch_queue.size() == 0);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_signed(int mag);
      return 32'($signed($urandom_range(2 * mag, 0)) - mag);
   endfunction

   task automatic random_map();
      logic [31:0] h0, h4;
      int mode;
      mode = $urandom_range(9);
      if (mode == 0) begin
         write_csr(CSR_X_GAINS, {$urandom, $urandom});
         write_csr(CSR_Y_GAINS, {$urandom, $urandom});
         write_csr(CSR_W_GAINS, {$urandom, $urandom});
         write_csr(CSR_X_OFFSET, {32'h0, $urandom});
         write_csr(CSR_Y_OFFSET, {32'h0, $urandom});
         write_csr(CSR_W_OFFSET, {32'h0, $urandom});
         write_csr(CSR_SRC_SIZE, {40'h0, 24'($urandom)});
         write_csr(CSR_OUT_HGT, {52'h0, 12'($urandom)});
      end else begin
         h0 = 32'($urandom_range(32'h2000_0000, 32'h0800_0000));
         h4 = 32'($urandom_range(32'h2000_0000, 32'h0800_0000));
         if ($urandom_range(3) == 0) h0 = -h0;
         if ($urandom_range(3) == 0) h4 = -h4;
         write_csr(CSR_X_GAINS, {rand_signed(32'h0400_0000), h0});
         write_csr(CSR_Y_GAINS, {h4, rand_signed(32'h0400_0000)});
         write_csr(CSR_W_GAINS, {rand_signed(1 << 23), rand_signed(1 << 23)});
         write_csr(CSR_X_OFFSET, {32'h0, rand_signed(400 << 16)});
         write_csr(CSR_Y_OFFSET, {32'h0, rand_signed(400 << 16)});
         write_csr(CSR_W_OFFSET, {32'h0, 32'($urandom_range(2 << 24, 1 << 23))});
         write_csr(CSR_SRC_SIZE, {40'h0, 12'($urandom_range(900, 1)),
                                  12'($urandom_range(900, 1))});
         write_csr(CSR_OUT_HGT, {52'h0, 12'($urandom_range(1000, 1))});
      end
   endtask

   always @(negedge clock) begin
      if (reset || pixel_queue.size() == 0) begin
         start <= 1'b0;
      end else if (idle_left > 0) begin
         idle_left <= idle_left - 1;
         start <= 1'b0;
      end else if (!calm && $urandom_range(7) == 0) begin
         idle_left <= $urandom_range(3, 1) - 1;
         start <= 1'b0;
      end else begin
         start <= 1'b1;
         req_dest_row <= pixel_queue[0].row;
         req_dest_col <= pixel_queue[0].col;
      end
   end

   always @(posedge clock) begin
      fetch_addr_type exp_addr;
      pixel_type p;
      if (!reset && rsp_valid) begin
         if (fetch_queue.size() == 0) begin
            $error("result with no transaction outstanding");
            failed = 1'b1;
         end else begin
            exp_addr = fetch_queue.pop_front();
            if (rsp_source_row !== exp_addr.row) begin
               $error("source_row expected %0d actual %0d", exp_addr.row, rsp_source_row);
               failed = 1'b1;
            end
            if (rsp_source_col !== exp_addr.col) begin
               $error("source_col expected %0d actual %0d", exp_addr.col, rsp_source_col);
               failed = 1'b1;
            end
            if (rsp_inside_res !== exp_addr.hit) begin
               $error("inside_res expected %0d actual %0d", exp_addr.hit,
                      rsp_inside_res);
               failed = 1'b1;
            end
         end
      end
      if (!reset && start && !busy) begin
         p = pixel_queue.pop_front();
         fetch_queue.push_back(map_pixel(p));
      end
   end

   initial begin
      #40_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      m_xg = 64'd268435456;
      m_yg = 64'd1152921504606846976;
      m_wg = '0;
      m_xo = '0;
      m_yo = '0;
      m_wo = 32'd16777216;
      m_size = 24'd2097664;
      m_oh = 12'd512;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_pixel(0, 0);
      push_pixel(4095, 4095);
      push_pixel(0, 4095);
      push_pixel(4095, 0);
      push_pixel(511, 511);
      push_pixel(512, 512);
      push_pixel(255, 256);
      drain();

      // w term zero everywhere
      write_csr(CSR_W_OFFSET, 64'h0);
      push_pixel(10, 20);
      push_pixel(4095, 4095);
      drain();

      // sub-pixel shift left: column in (-1, 0) truncates to zero
      write_csr(CSR_W_OFFSET, 64'd16777216);
      write_csr(CSR_X_OFFSET, 64'hFFFF_B333);
      write_csr(CSR_Y_OFFSET, 64'h0000_4CCD);
      push_pixel(0, 0);
      push_pixel(511, 0);
      push_pixel(0, 511);
      drain();

      // empty source, zero output height, unmapped index
      write_csr(CSR_SRC_SIZE, 64'h0);
      write_csr(CSR_OUT_HGT, 64'h0);
      write_csr(CSR_UNMAPPED, {64{1'b1}});
      push_pixel(0, 0);
      push_pixel(100, 100);
      drain();

      // coefficient extremes
      write_csr(CSR_X_GAINS, 64'h7FFF_FFFF_8000_0000);
      write_csr(CSR_Y_GAINS, 64'h8000_0000_7FFF_FFFF);
      write_csr(CSR_W_GAINS, 64'h8000_0000_8000_0000);
      write_csr(CSR_X_OFFSET, 64'h7FFF_FFFF);
      write_csr(CSR_Y_OFFSET, 64'h8000_0000);
      write_csr(CSR_W_OFFSET, 64'h7FFF_FFFF);
      write_csr(CSR_SRC_SIZE, 64'hFF_FFFF);
      write_csr(CSR_OUT_HGT, 64'hFFF);
      push_pixel(0, 0);
      push_pixel(4095, 4095);
      push_pixel(2048, 1);
      drain();

      for (int ph = 0; ph < 12; ph++) begin
         random_map();
         if (ph == 11) calm = 1'b1;
         for (int k = 0; k < 160; k++) begin
            if ($urandom_range(9) == 0)
               push_pixel($urandom_range(4095), $urandom_range(4095));
            else
               push_pixel($urandom_range(m_oh), $urandom_range(1000));
         end
         drain();
      end

      repeat (2 * LATENCY) @(posedge clock);
      if (!failed && fetch_queue.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/ihm_pkg.sv
rtl/inverse_homography_mapper_top.sv
sim/tb_inverse_homography_mapper_top.sv
